/* sv/bitmap_and_find_first_clear_macros.svh */
// Assertion helpers used by bitmap_and_find_first_clear.
`ifndef BITMAP_AND_FIND_FIRST_CLEAR_MACROS_SVH
`define BITMAP_AND_FIND_FIRST_CLEAR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BAFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BAFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bafc_pkg.sv */
package bafc_pkg;

    localparam int IDX_W      = 12;
    localparam int BIT_W      = 5;
    localparam int DATA_W     = 32;
    localparam int CWORD_W    = IDX_W - BIT_W;
    localparam int MAX_WORDS  = 1 << CWORD_W;

    localparam logic [1:0] CMD_SET_A = 2'd0;
    localparam logic [1:0] CMD_SET_B = 2'd1;
    localparam logic [1:0] CMD_FIND  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    typedef struct packed {
        logic rd_en;
        logic wr_a;
        logic wr_b;
    } t_mem_ctl;

endpackage

/* sv/bafc_in_if.sv */
interface bafc_in_if import bafc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [IDX_W-1:0]   cell_index;
    logic [IDX_W-1:0]   start_index;

    modport source (output valid, cmd, cell_index, start_index, input ready);
    modport sink   (input valid, cmd, cell_index, start_index, output ready);
endinterface

/* sv/bafc_out_if.sv */
interface bafc_out_if import bafc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               found;
    logic [IDX_W-1:0]   found_index;

    modport source (output valid, found, found_index, input ready);
    modport sink   (input valid, found, found_index, output ready);
endinterface

/* sv/bafc_mem.sv */
module bafc_mem import bafc_pkg::*; #(
    parameter int WORD_COUNT = 128
) (
    input  logic                              i_clk,
    input  t_mem_ctl                          i_ctl,
    input  logic [$clog2(WORD_COUNT)-1:0]     i_rd_addr,
    input  logic [$clog2(WORD_COUNT)-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0]                 i_wr_data_a,
    input  logic [DATA_W-1:0]                 i_wr_data_b,
    output logic [DATA_W-1:0]                 o_rd_data_a,
    output logic [DATA_W-1:0]                 o_rd_data_b
);

    logic [DATA_W-1:0] r_map_a [WORD_COUNT];
    logic [DATA_W-1:0] r_map_b [WORD_COUNT];

    // map A storage, one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_a) begin
            r_map_a[i_wr_addr] <= i_wr_data_a;
        end
        if (i_ctl.rd_en) begin
            o_rd_data_a <= r_map_a[i_rd_addr];
        end
    end

    // map B storage
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_b) begin
            r_map_b[i_wr_addr] <= i_wr_data_b;
        end
        if (i_ctl.rd_en) begin
            o_rd_data_b <= r_map_b[i_rd_addr];
        end
    end

endmodule

/* sv/bafc_ffs.sv */
module bafc_ffs import bafc_pkg::*; (
    input  logic [DATA_W-1:0] i_word,
    output logic              o_any,
    output logic [BIT_W-1:0]  o_bit
);

    // lowest set bit wins: walk down so the last hit is the lowest
    always_comb begin
        o_bit = '0;
        for (int i = DATA_W - 1; i >= 0; i--) begin
            if (i_word[i]) begin
                o_bit = BIT_W'(i);
            end
        end
        o_any = |i_word;
    end

endmodule

/* sv/bitmap_and_find_first_clear.sv */
// Pair of cell bitmaps (A and B) with "find first common cell and clear it".
// Input channel i_in carries cmd, cell_index and start_index; each command
// yields exactly one transfer on the output channel o_out (found, found_index).
//   set A / set B : read-modify-write of one word; result is all zeros.
//                   The word is read, written back in ST_SET_WR, then passed on via ST_DONE.
//   find          : scans one word pair per cycle from word start_index/32,
//                   clears the first common bit in both maps on a hit.
//                   The scan ends at the first hit or after word
//                   min(WORD_COUNT,128)-1, then the result is passed on via ST_DONE.
//   no-op         : result of zeros, passed on via ST_DONE.
// One command is in work at a time; the scan loop over the shared word
// memory port sets the throughput, so a full miss costs the scan length.
// The output register lets the next command be taken while a result still
// waits on a stalled receiver; the engine holds its finished result until
// the output register frees up, and only then returns to take new input.
// After reset the block sweeps both maps to zero, one word per cycle, through
// all WORD_COUNT words; i_in.ready stays low during that sweep.
`include "bitmap_and_find_first_clear_macros.svh"

module bitmap_and_find_first_clear import bafc_pkg::*; #(
    parameter int GRID_SIDE  = 16,
    parameter int WORD_COUNT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bafc_in_if.sink     i_in,
    bafc_out_if.source  o_out
);

    localparam int AW         = $clog2(WORD_COUNT);
    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    // cells above the 12-bit index range can never be set, so stop there
    localparam int SCAN_WORDS = (WORD_COUNT < MAX_WORDS) ? WORD_COUNT : MAX_WORDS;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SET_WR = 3'd2;
    localparam logic [2:0] ST_FIND   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [CWORD_W-1:0] r_word, n_word;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic               r_sel_b, n_sel_b;
    logic               r_res_found, n_res_found;
    logic [IDX_W-1:0]   r_res_idx, n_res_idx;
    logic               r_o_valid, n_o_valid;
    logic               r_o_found, n_o_found;
    logic [IDX_W-1:0]   r_o_idx, n_o_idx;

    t_mem_ctl           mem_ctl;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [DATA_W-1:0]  wr_data_a, wr_data_b, rd_a, rd_b, both;
    logic               ffs_any;
    logic [BIT_W-1:0]   ffs_bit;

    logic [CWORD_W-1:0] cell_word, start_word;
    logic               cell_ok, start_ok;
    logic [CWORD_W:0]   word_next;
    logic [DATA_W-1:0]  set_word;
    logic               load_out;

    bafc_mem #(
        .WORD_COUNT (WORD_COUNT)
    ) u_mem (
        .i_clk       (i_clk),
        .i_ctl       (mem_ctl),
        .i_rd_addr   (rd_addr),
        .i_wr_addr   (wr_addr),
        .i_wr_data_a (wr_data_a),
        .i_wr_data_b (wr_data_b),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    assign both = rd_a & rd_b;

    bafc_ffs u_ffs (
        .i_word (both),
        .o_any  (ffs_any),
        .o_bit  (ffs_bit)
    );

    // decode of the incoming command
    assign cell_word  = i_in.cell_index[IDX_W-1:BIT_W];
    assign start_word = i_in.start_index[IDX_W-1:BIT_W];
    assign cell_ok    = (32'(i_in.cell_index) < CELL_COUNT) && (32'(cell_word) < WORD_COUNT);
    assign start_ok   = 32'(start_word) < SCAN_WORDS;
    assign word_next  = {1'b0, r_word} + (CWORD_W + 1)'(1);
    assign set_word   = (r_sel_b ? rd_b : rd_a) | (DATA_W'(1) << r_bit);

    assign i_in.ready = (r_state == ST_IDLE);
    assign load_out   = (r_state == ST_DONE) && (!r_o_valid || o_out.ready);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_word      = r_word;
        n_bit       = r_bit;
        n_sel_b     = r_sel_b;
        n_res_found = r_res_found;
        n_res_idx   = r_res_idx;
        mem_ctl     = '0;
        rd_addr     = '0;
        wr_addr     = '0;
        wr_data_a   = '0;
        wr_data_b   = '0;

        unique case (r_state)
            ST_CLEAR: begin
                // zero one word of both maps per cycle
                mem_ctl.wr_a = 1'b1;
                mem_ctl.wr_b = 1'b1;
                wr_addr      = r_clr;
                n_clr        = r_clr + AW'(1);
                if (r_clr == AW'(WORD_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_res_found = 1'b0;
                    n_res_idx   = '0;
                    n_state     = ST_DONE;
                    priority if ((i_in.cmd == CMD_SET_A || i_in.cmd == CMD_SET_B) && cell_ok)
                    begin
                        // fetch the word, set the bit next cycle
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = AW'(cell_word);
                        n_word        = cell_word;
                        n_bit         = i_in.cell_index[BIT_W-1:0];
                        n_sel_b       = (i_in.cmd == CMD_SET_B);
                        n_state       = ST_SET_WR;
                    end else if (i_in.cmd == CMD_FIND && start_ok) begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = AW'(start_word);
                        n_word        = start_word;
                        n_state       = ST_FIND;
                    end else begin
                        // no-op, out-of-grid set, or start past the maps
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SET_WR: begin
                mem_ctl.wr_a = !r_sel_b;
                mem_ctl.wr_b = r_sel_b;
                wr_addr      = AW'(r_word);
                wr_data_a    = set_word;
                wr_data_b    = set_word;
                n_state      = ST_DONE;
            end
            ST_FIND: begin
                if (ffs_any) begin
                    // clear the hit in both maps and report it
                    mem_ctl.wr_a = 1'b1;
                    mem_ctl.wr_b = 1'b1;
                    wr_addr      = AW'(r_word);
                    wr_data_a    = rd_a & ~(DATA_W'(1) << ffs_bit);
                    wr_data_b    = rd_b & ~(DATA_W'(1) << ffs_bit);
                    n_res_found  = 1'b1;
                    n_res_idx    = {r_word, ffs_bit};
                    n_state      = ST_DONE;
                end else if (32'(word_next) < SCAN_WORDS) begin
                    // advance to the next word pair
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = AW'(word_next[CWORD_W-1:0]);
                    n_word        = word_next[CWORD_W-1:0];
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register: drop on transfer, load from the engine
    always_comb begin
        n_o_valid = r_o_valid && !o_out.ready;
        n_o_found = r_o_found;
        n_o_idx   = r_o_idx;
        if (load_out) begin
            n_o_valid = 1'b1;
            n_o_found = r_res_found;
            n_o_idx   = r_res_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word      <= n_word;
        r_bit       <= n_bit;
        r_sel_b     <= n_sel_b;
        r_res_found <= n_res_found;
        r_res_idx   <= n_res_idx;
        r_o_found   <= n_o_found;
        r_o_idx     <= n_o_idx;
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.found       = r_o_found;
    assign o_out.found_index = r_o_idx;

    // no input taken while the maps are being swept
    `BAFC_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n,
        r_state == ST_CLEAR, !i_in.ready, "input accepted during clear sweep")
    // a find hit clears exactly one bit of each map
    `BAFC_ASSERT_NOW(a_find_clears_one, i_clk, i_rst_n,
        r_state == ST_FIND && mem_ctl.wr_a,
        $countones(rd_a ^ wr_data_a) == 1 && $countones(rd_b ^ wr_data_b) == 1,
        "find write-back changed other than one bit")
    // engine goes busy right after taking a command
    `BAFC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_in.valid && i_in.ready, r_state != ST_IDLE, "engine idle after input transfer")
    // a set never writes both maps at once
    `BAFC_ASSERT_NOW(a_set_one_map, i_clk, i_rst_n,
        r_state == ST_SET_WR, mem_ctl.wr_a != mem_ctl.wr_b, "set wrote both or neither map")

endmodule
